@@ rtl/core/cclr_pkg.sv @@
// Shared constants and keyword tables of the comma command line recognizer.
package cclr_pkg;

    localparam int MAX_LINE_DEF = 32;
    localparam int NUM_KW       = 8;
    localparam int TEAM_W       = 32;
    localparam int BYTE_W       = 8;
    localparam int CODE_W       = 4;
    localparam int CHAR_CNT_W   = 5;
    localparam int FIELD_W      = 2;

    localparam logic [TEAM_W-1:0] TEAM_ID_RST = 32'h3130_3835;

    localparam logic [BYTE_W-1:0] CH_START = 8'h43;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

    localparam logic [CODE_W-1:0] CODE_NONE = 4'd0;

    localparam logic [FIELD_W-1:0] FIELD_TEAM = 2'd1;
    localparam logic [FIELD_W-1:0] FIELD_KW   = 2'd2;
    localparam logic [FIELD_W-1:0] FIELD_LAST = 2'd3;

    localparam logic [CHAR_CNT_W-1:0] TEAM_LEN = 5'd4;
    localparam logic [CHAR_CNT_W-1:0] CHAR_MAX = 5'd31;

    // Keyword k carries command code k+1: CX, SIM, SIMP, CAL, ST, BK, CR, TC.
    localparam logic [BYTE_W-1:0] KW_TEXT [NUM_KW][4] = '{
        '{8'h43, 8'h58, 8'h00, 8'h00},
        '{8'h53, 8'h49, 8'h4D, 8'h00},
        '{8'h53, 8'h49, 8'h4D, 8'h50},
        '{8'h43, 8'h41, 8'h4C, 8'h00},
        '{8'h53, 8'h54, 8'h00, 8'h00},
        '{8'h42, 8'h4B, 8'h00, 8'h00},
        '{8'h43, 8'h52, 8'h00, 8'h00},
        '{8'h54, 8'h43, 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd2, 3'd3, 3'd4, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2
    };

endpackage

@@ rtl/core/cclr_ifs.sv @@
// Handshake channel interfaces of the comma command line recognizer.
interface cclr_rx_if import cclr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cclr_res_if import cclr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] command_code;
    logic              line_overflow;

    modport source (output valid, output command_code, output line_overflow, input ready);
    modport sink   (input valid, input command_code, input line_overflow, output ready);
endinterface

interface cclr_cfg_if import cclr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TEAM_W-1:0] team_id_chars;

    modport source (output valid, output team_id_chars, input ready);
    modport sink   (input valid, input team_id_chars, output ready);
endinterface

@@ rtl/core/comma_command_line_recognizer.sv @@
// Top level of the comma command line recognizer: input register, byte parser and result register.
//
// Usage: received serial bytes enter on i_rx, one item per byte. Bytes are
// dropped until a 'C' opens a line; inside a line commas split fields and a
// carriage return ends it. Each carriage return inside a line yields exactly
// one item on o_res: the command code (0 when the team field or the keyword
// field does not match exactly or the line overflowed) and a flag set when
// the line ran past MAX_LINE bytes. All other bytes yield nothing.
// i_cfg writes the four-character team identifier; it is always ready and is
// meant to be written while no byte is in flight.
// Throughput: one byte per cycle but for the stall below. A carriage return
// inside a line passes from the input register into the result register,
// which drives o_res.valid.
// When o_res stalls, a waiting result stays put; bytes that make no result
// still flow, and only a second carriage return holds in the input register
// until the result register is free.
// Reset clears the line state and loads the team identifier "1085".
module comma_command_line_recognizer import cclr_pkg::*; #(
    parameter int MAX_LINE = MAX_LINE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cclr_rx_if.sink     i_rx,
    cclr_cfg_if.sink    i_cfg,
    cclr_res_if.source  o_res
);

    localparam int LEN_W = $clog2(MAX_LINE + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LINE);

    // Input register.
    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;

    // Line state.
    logic                  r_in_line,  n_in_line;
    logic [FIELD_W-1:0]    r_field,    n_field;
    logic [CHAR_CNT_W-1:0] r_char_cnt, n_char_cnt;
    logic [LEN_W-1:0]      r_line_len, n_line_len;
    logic                  r_team_ok,  n_team_ok;
    logic [NUM_KW-1:0]     r_kw_cand,  n_kw_cand;
    logic                  r_ovf,      n_ovf;
    logic [TEAM_W-1:0]     r_team_id;

    // Result register.
    logic              r_out_vld;
    logic [CODE_W-1:0] r_out_code, n_out_code;
    logic              r_out_ovf;

    logic              is_result;
    logic              proc_fire;
    logic [NUM_KW-1:0] kw_len_hit;
    logic [NUM_KW-1:0] kw_char_hit;
    logic [NUM_KW-1:0] kw_final;
    logic [BYTE_W-1:0] team_char;
    logic              team_char_hit;

    // A carriage return inside a line needs room in the result register.
    assign is_result = r_in_line && (r_in_byte == CH_CR);
    assign proc_fire = r_in_vld && (!is_result || !r_out_vld || o_res.ready);

    assign i_rx.ready  = !r_in_vld || proc_fire;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid         = r_out_vld;
    assign o_res.command_code  = r_out_code;
    assign o_res.line_overflow = r_out_ovf;

    // Per-keyword checks of the current byte and of the field length.
    always_comb begin
        for (int k = 0; k < NUM_KW; k++) begin
            kw_len_hit[k]  = (r_char_cnt == {2'b00, KW_LEN[k]});
            kw_char_hit[k] = (r_char_cnt < {2'b00, KW_LEN[k]})
                          && (KW_TEXT[k][r_char_cnt[1:0]] == r_in_byte);
        end
    end

    // Team character at the current position, first character in the top byte.
    always_comb begin
        case (r_char_cnt[1:0])
            2'd0:    team_char = r_team_id[31:24];
            2'd1:    team_char = r_team_id[23:16];
            2'd2:    team_char = r_team_id[15:8];
            default: team_char = r_team_id[7:0];
        endcase
    end
    assign team_char_hit = (r_char_cnt < TEAM_LEN) && (team_char == r_in_byte);

    // Keyword field closed by the carriage return when it is still the open one.
    assign kw_final = (r_field == FIELD_KW) ? (r_kw_cand & kw_len_hit) : r_kw_cand;

    // Code of the first surviving keyword, if the line qualifies.
    always_comb begin
        n_out_code = CODE_NONE;
        if (!r_ovf && (r_field >= FIELD_KW) && r_team_ok) begin
            for (int k = NUM_KW - 1; k >= 0; k--) begin
                if (kw_final[k]) begin
                    n_out_code = CODE_W'(k + 1);
                end
            end
        end
    end

    // Next line state for the byte in the input register.
    always_comb begin
        n_in_line  = r_in_line;
        n_field    = r_field;
        n_char_cnt = r_char_cnt;
        n_line_len = r_line_len;
        n_team_ok  = r_team_ok;
        n_kw_cand  = r_kw_cand;
        n_ovf      = r_ovf;
        if (!r_in_line) begin
            // The opening 'C' is the first character of field zero.
            if (r_in_byte == CH_START) begin
                n_in_line  = 1'b1;
                n_field    = '0;
                n_char_cnt = CHAR_CNT_W'(1);
                n_line_len = LEN_W'(1);
                n_team_ok  = 1'b1;
                n_kw_cand  = '1;
                n_ovf      = 1'b0;
            end
        end else if (r_in_byte == CH_CR) begin
            n_in_line  = 1'b0;
            n_field    = '0;
            n_char_cnt = '0;
            n_line_len = '0;
            n_team_ok  = 1'b1;
            n_kw_cand  = '1;
            n_ovf      = 1'b0;
        end else begin
            if (r_line_len >= LEN_MAX) begin
                n_ovf = 1'b1;
            end else begin
                n_line_len = r_line_len + LEN_W'(1);
            end
            if (r_in_byte == CH_COMMA) begin
                if (r_field == FIELD_TEAM) begin
                    n_team_ok = r_team_ok && (r_char_cnt == TEAM_LEN);
                end else if (r_field == FIELD_KW) begin
                    n_kw_cand = r_kw_cand & kw_len_hit;
                end
                if (r_field != FIELD_LAST) begin
                    n_field = r_field + FIELD_W'(1);
                end
                n_char_cnt = '0;
            end else begin
                if (r_field == FIELD_TEAM) begin
                    n_team_ok = r_team_ok && team_char_hit;
                end else if (r_field == FIELD_KW) begin
                    n_kw_cand = r_kw_cand & kw_char_hit;
                end
                if (r_char_cnt != CHAR_MAX) begin
                    n_char_cnt = r_char_cnt + CHAR_CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_in_line  <= 1'b0;
            r_field    <= '0;
            r_char_cnt <= '0;
            r_line_len <= '0;
            r_team_ok  <= 1'b1;
            r_kw_cand  <= '1;
            r_ovf      <= 1'b0;
            r_team_id  <= TEAM_ID_RST;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_rx.valid && i_rx.ready) begin
                r_in_vld <= 1'b1;
            end else if (proc_fire) begin
                r_in_vld <= 1'b0;
            end
            if (proc_fire) begin
                r_in_line  <= n_in_line;
                r_field    <= n_field;
                r_char_cnt <= n_char_cnt;
                r_line_len <= n_line_len;
                r_team_ok  <= n_team_ok;
                r_kw_cand  <= n_kw_cand;
                r_ovf      <= n_ovf;
            end
            if (i_cfg.valid) begin
                r_team_id <= i_cfg.team_id_chars;
            end
            if (proc_fire && is_result) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (proc_fire && is_result) begin
            r_out_code <= n_out_code;
            r_out_ovf  <= r_ovf;
        end
    end

`ifndef ASSERT_OFF
    // An overflowed line never reports a command.
    a_ovf_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.line_overflow |-> o_res.command_code == CODE_NONE)
        else $error("overflowed line gave a command code");

    // The line length counter never passes its bound.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_len <= LEN_MAX)
        else $error("line length beyond bound");

    // The overflow flag is only set once the length counter has saturated.
    a_ovf_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_line_len == LEN_MAX)
        else $error("overflow flag without full line length");

    // Outside a line the match state is back at its clean values.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_line |-> (r_kw_cand == '1) && r_team_ok && !r_ovf
                       && (r_field == '0) && (r_line_len == '0))
        else $error("stale line state outside a line");

    // A byte held back by a stalled result keeps its value.
    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !proc_fire |=> r_in_vld && $stable(r_in_byte))
        else $error("held input byte was lost or changed");
`endif

endmodule

@@ sim/tb.sv @@
// Self-checking testbench of the comma command line recognizer.
`timescale 1ns / 100ps

module tb;
    import cclr_pkg::*;

    localparam int LINE_LIMIT   = MAX_LINE_DEF;
    localparam int DRAIN_CYCLES = 6;      // input register plus result register, with margin
    localparam int HOLD_CYCLES  = 150;    // long receiver hold-off in the backpressure test
    localparam int PHASE_BYTES  = 200;    // bytes per team setting in the random traffic
    localparam int TIME_LIMIT   = 2000000;

    typedef enum logic [CODE_W-1:0] {
        CMD_NONE = CODE_NONE,
        CMD_CX,
        CMD_SIM,
        CMD_SIMP,
        CMD_CAL,
        CMD_ST,
        CMD_BK,
        CMD_CR,
        CMD_TC
    } t_cmd_code;

    typedef struct packed {
        t_cmd_code code;
        logic      overflow;
    } t_line_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cclr_rx_if  rx_ch ();
    cclr_cfg_if cfg_ch ();
    cclr_res_if res_ch ();

    comma_command_line_recognizer #(
        .MAX_LINE (LINE_LIMIT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Line tracker: a private copy of the parser state, updated on every
    // accepted byte. Expected verdicts wait in arrival order.
    logic [TEAM_W-1:0]     team_word = TEAM_ID_RST;
    logic                  line_open;
    logic [FIELD_W-1:0]    fld_idx;
    logic [CHAR_CNT_W-1:0] fld_len;
    logic [5:0]            line_bytes;
    logic                  team_match;
    logic [NUM_KW-1:0]     kw_alive;
    logic                  line_too_long;

    t_line_verdict pending_verdicts[$];
    logic [7:0]    line_buf[$];

    int  fail_count       = 0;
    int  rx_bytes         = 0;
    bit  src_steady       = 1'b0;
    bit  sink_steady      = 1'b0;
    int  sink_hold_reqs   = 0;
    int  sink_holds_taken = 0;
    int  sink_stall_left  = 0;
    int  sink_gap;

    function automatic void clear_line();
        line_open     = 1'b0;
        fld_idx       = '0;
        fld_len       = '0;
        line_bytes    = '0;
        team_match    = 1'b1;
        kw_alive      = '1;
        line_too_long = 1'b0;
    endfunction

    function automatic logic [7:0] team_char(input int pos);
        return team_word[TEAM_W-1-8*pos -: 8];
    endfunction

    // A field has ended: its length alone can still rule it out.
    function automatic void judge_field_length();
        if (fld_idx == FIELD_TEAM) begin
            if (fld_len != TEAM_LEN)
                team_match = 1'b0;
        end else if (fld_idx == FIELD_KW) begin
            for (int k = 0; k < NUM_KW; k++)
                if (CHAR_CNT_W'(KW_LEN[k]) != fld_len)
                    kw_alive[k] = 1'b0;
        end
    endfunction

    // One character of a field: compare it at its position.
    function automatic void judge_char(input logic [7:0] c);
        int pos;
        pos = int'(fld_len);
        if (fld_idx == FIELD_TEAM) begin
            if (pos >= TEAM_LEN)
                team_match = 1'b0;
            else if (team_char(pos) != c)
                team_match = 1'b0;
        end else if (fld_idx == FIELD_KW) begin
            for (int k = 0; k < NUM_KW; k++) begin
                if (pos >= KW_LEN[k])
                    kw_alive[k] = 1'b0;
                else if (KW_TEXT[k][pos] != c)
                    kw_alive[k] = 1'b0;
            end
        end
        if (fld_len < CHAR_MAX)
            fld_len++;
    endfunction

    function automatic void track_rx_byte(input logic [7:0] c);
        t_line_verdict v;
        if (!line_open) begin
            // Outside a line only the start character matters.
            if (c != CH_START)
                return;
            clear_line();
            line_open = 1'b1;
        end else if (c == CH_CR) begin
            if (fld_idx <= FIELD_KW)
                judge_field_length();
            v.code     = CMD_NONE;
            v.overflow = line_too_long;
            if (!line_too_long && fld_idx >= FIELD_KW && team_match) begin
                // The lowest surviving keyword wins.
                for (int k = NUM_KW - 1; k >= 0; k--)
                    if (kw_alive[k])
                        v.code = t_cmd_code'(k + 1);
            end
            pending_verdicts.push_back(v);
            clear_line();
            return;
        end

        if (line_bytes >= LINE_LIMIT)
            line_too_long = 1'b1;
        else
            line_bytes++;

        if (c == CH_COMMA) begin
            if (fld_idx <= FIELD_KW)
                judge_field_length();
            if (fld_idx < FIELD_LAST)
                fld_idx++;
            fld_len = '0;
        end else begin
            judge_char(c);
        end
    endfunction

    // Gap lengths: mostly none, often short, now and then a long one.
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result side: random stalls, plus a long hold-off when a test asks for one.
    always @(negedge i_clk) begin
        if (sink_hold_reqs != sink_holds_taken) begin
            sink_holds_taken++;
            sink_stall_left = HOLD_CYCLES;
        end
        if (sink_stall_left > 0) begin
            res_ch.ready <= 1'b0;
            sink_stall_left--;
        end else begin
            sink_gap = pick_gap(sink_steady);
            if (sink_gap == 0) begin
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= 1'b0;
                sink_stall_left = sink_gap - 1;
            end
        end
    end

    // Every accepted result is matched against the oldest expected verdict.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result with nothing expected: code %0d overflow %0b",
                         $time, res_ch.command_code, res_ch.line_overflow);
                fail_count++;
            end else begin
                t_line_verdict v;
                v = pending_verdicts.pop_front();
                if (res_ch.command_code !== v.code) begin
                    $display("%0t: command_code expected %0d actual %0d",
                             $time, v.code, res_ch.command_code);
                    fail_count++;
                end
                if (res_ch.line_overflow !== v.overflow) begin
                    $display("%0t: line_overflow expected %0b actual %0b",
                             $time, v.overflow, res_ch.line_overflow);
                    fail_count++;
                end
            end
        end
    end

    // Offer one byte after a random gap and hold it until it is taken. Valid
    // stays high afterwards; at the next falling edge the next call offers a
    // new byte or lowers it, as a wait does, so no edge takes a byte twice.
    task automatic send_rx_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap(src_steady);
        if (gap > 0) begin
            @(negedge i_clk);
            rx_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        track_rx_byte(b);
        rx_bytes++;
    endtask

    task automatic send_line_buf();
        foreach (line_buf[i])
            send_rx_byte(line_buf[i]);
        line_buf.delete();
    endtask

    // Stop offering and wait until every expected verdict has come, then let
    // the pipeline settle so that the block is truly idle.
    task automatic wait_for_results();
        @(negedge i_clk);
        rx_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_team_id(input logic [TEAM_W-1:0] value);
        wait_for_results();
        @(negedge i_clk);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.team_id_chars <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        team_word = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    function automatic void put_cr();
        line_buf.push_back(CH_CR);
    endfunction

    function automatic void put_team();
        for (int p = 0; p < 4; p++)
            line_buf.push_back(team_char(p));
    endfunction

    function automatic void put_keyword(input int k);
        for (int p = 0; p < KW_LEN[k]; p++)
            line_buf.push_back(KW_TEXT[k][p]);
    endfunction

    function automatic logic [7:0] rand_letter();
        string pool;
        pool = "CXSIMPALTBKRcs";
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    function automatic logic [7:0] rand_body_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_CR);
        return b;
    endfunction

    function automatic logic [TEAM_W-1:0] rand_team();
        logic [TEAM_W-1:0] w;
        logic [7:0]        b;
        for (int p = 0; p < 4; p++) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_COMMA || b == CH_CR);
            w[TEAM_W-1-8*p -: 8] = b;
        end
        return w;
    endfunction

    // A command line with random content and random defects: wrong, short or
    // long team field, near-miss keywords, missing, extra and overlong fields.
    function automatic void build_random_line();
        int         r;
        int         k;
        int         pos;
        logic [7:0] b;
        line_buf.push_back(CH_START);
        repeat ($urandom_range(0, 3)) line_buf.push_back(rand_letter());
        if ($urandom_range(0, 99) < 4) begin
            put_cr();
            return;
        end

        line_buf.push_back(CH_COMMA);
        r   = $urandom_range(0, 99);
        pos = $urandom_range(0, 3);
        if (r < 65) begin
            put_team();
        end else if (r < 75) begin
            for (int p = 0; p < 4; p++) begin
                b = team_char(p);
                if (p == pos)
                    b = b ^ (8'h01 << $urandom_range(0, 7));
                line_buf.push_back(b);
            end
        end else if (r < 82) begin
            for (int p = 0; p < pos; p++)
                line_buf.push_back(team_char(p));
        end else if (r < 90) begin
            put_team();
            line_buf.push_back(rand_letter());
        end else begin
            repeat ($urandom_range(1, 6)) line_buf.push_back(rand_letter());
        end
        if ($urandom_range(0, 99) < 8) begin
            put_cr();
            return;
        end

        line_buf.push_back(CH_COMMA);
        r = $urandom_range(0, 99);
        k = $urandom_range(0, NUM_KW - 1);
        if (r < 70) begin
            put_keyword(k);
        end else if (r < 78) begin
            for (int p = 0; p < KW_LEN[k] - 1; p++)
                line_buf.push_back(KW_TEXT[k][p]);
        end else if (r < 86) begin
            put_keyword(k);
            line_buf.push_back(rand_letter());
        end else if (r < 93) begin
            pos = $urandom_range(0, KW_LEN[k] - 1);
            for (int p = 0; p < KW_LEN[k]; p++)
                line_buf.push_back(p == pos ? rand_letter() : KW_TEXT[k][p]);
        end else begin
            repeat ($urandom_range(1, 4)) line_buf.push_back(rand_letter());
        end

        if ($urandom_range(0, 99) < 25) begin
            repeat ($urandom_range(1, 2)) begin
                line_buf.push_back(CH_COMMA);
                repeat ($urandom_range(0, 6)) line_buf.push_back(rand_body_byte());
            end
        end
        if ($urandom_range(0, 99) < 8) begin
            line_buf.push_back(CH_COMMA);
            repeat ($urandom_range(20, 45)) line_buf.push_back(rand_body_byte());
        end
        put_cr();
    endfunction

    // Bytes outside a line, including a carriage return and a comma, give nothing.
    task automatic test_noise_outside_line();
        line_buf = '{8'h00, 8'hFF, CH_CR, CH_COMMA, 8'h58, 8'h80, 8'h7F, CH_CR};
        send_line_buf();
    endtask

    task automatic test_every_keyword();
        for (int k = 0; k < NUM_KW; k++) begin
            put_text(k == 0 ? "CMD," : "C,");
            put_team();
            put_text(",");
            put_keyword(k);
            put_cr();
            send_line_buf();
        end
    endtask

    // Extra fields, missing fields, empty fields and near misses.
    task automatic test_field_rules();
        string lines[10];
        lines = '{"CC,1085,SIMP,x,y", "C,1085", "C", "C,1085,", "C,,CX",
                  "C,1086,CX", "C,10855,BK", "C,1085,SI", "C,1085,CXX", "C,1085,cr"};
        foreach (lines[i]) begin
            put_text(lines[i]);
            put_cr();
            send_line_buf();
        end
    endtask

    // Exactly the longest allowed line, one byte more, and a field so long that
    // its character count saturates.
    task automatic test_line_length();
        for (int extra = 0; extra < 2; extra++) begin
            put_text("C,1085,TC,");
            repeat (LINE_LIMIT - 10 + extra) line_buf.push_back(8'h5A);
            put_cr();
            send_line_buf();
        end
        put_text("C,1085,");
        repeat (40) line_buf.push_back(8'h53);
        put_cr();
        send_line_buf();
    endtask

    // Team identifiers of all ones and all zeros; the old identifier must fail.
    task automatic test_team_extremes();
        write_team_id('1);
        put_text("C,");
        put_team();
        put_text(",CAL");
        put_cr();
        put_text("C,1085,CAL");
        put_cr();
        send_line_buf();
        write_team_id('0);
        put_text("C,");
        put_team();
        put_text(",ST");
        put_cr();
        send_line_buf();
    endtask

    // The receiver holds off long while lines keep coming, so the block must
    // stall its input; then the sender pauses until everything has drained.
    task automatic test_backpressure();
        write_team_id(TEAM_ID_RST);
        src_steady = 1'b1;
        sink_hold_reqs++;
        repeat (8) build_random_line();
        send_line_buf();
        wait_for_results();
        repeat (4) build_random_line();
        send_line_buf();
        src_steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        int         phase_start;
        int         r;
        for (int phase = 0; phase < 6; phase++) begin
            write_team_id(phase == 0 ? TEAM_ID_RST : rand_team());
            // Phase two, and at random others, run without any idling on either side.
            src_steady  = (phase == 2) || ($urandom_range(0, 3) == 0);
            sink_steady = (phase == 2) || ($urandom_range(0, 3) == 0);
            phase_start = rx_bytes;
            while (rx_bytes - phase_start < PHASE_BYTES) begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    build_random_line();
                end else if (r < 88) begin
                    repeat ($urandom_range(1, 6))
                        line_buf.push_back(8'($urandom_range(0, 255)));
                end else begin
                    line_buf.push_back(CH_START);
                    repeat ($urandom_range(1, 12)) line_buf.push_back(rand_body_byte());
                    put_cr();
                end
                send_line_buf();
            end
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    initial begin
        clear_line();
        i_rst_n              = 1'b0;
        rx_ch.valid          = 1'b0;
        rx_ch.rx_byte        = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.team_id_chars = '0;
        res_ch.ready         = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_noise_outside_line();
        test_every_keyword();
        test_field_rules();
        test_line_length();
        test_team_extremes();
        test_backpressure();
        test_random_traffic();

        wait_for_results();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // A hung handshake or a missing result ends here.
    initial begin
        #(TIME_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

endmodule
